[rtl/mdds_pkg.sv]
// ----------------------------------------------------------------------------
// mdds_pkg
// Shared types, constants and elaboration-time tables for the MIDI voice
// DDS oscillator: beat formats, command and waveform codes, the per-key phase
// step table and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package mdds_pkg;

  localparam int SAMPLE_HZ   = 48000;
  localparam int PHASE_BITS  = 32;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_AW     = $clog2(SINE_DEPTH);
  localparam int ROM_AW      = SINE_AW + 1;
  localparam int NUM_KEYS    = 128;

  // datapath widths
  localparam int VEL_W       = 7;
  localparam int RAW_W       = 17;            // Q15 with +1.0 representable
  localparam int PROD_W      = RAW_W + VEL_W + 1;
  localparam int MAG_W       = 22;            // |raw * vel| + 63 < 2^22
  localparam int SAMPLE_W    = 16;

  // divide by 127 as multiply by ceil(2^30 / 127) then shift
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam longint unsigned RECIP_MUL = ((64'd1 << RECIP_SHIFT) + 64'd126) / 64'd127;
  localparam int RND_BIAS    = 63;

  localparam longint unsigned STEP_DEN    = 64'(SAMPLE_HZ) * 64'd1000;
  localparam longint          HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2
  } cmd_t;

  // sine, sawtooth, square, triangle
  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_RAMP   = 2'd1,
    WAVE_PULSE  = 2'd2,
    WAVE_TENT   = 2'd3
  } wave_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [VEL_W-1:0] key;
    logic [VEL_W-1:0] strike;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       voice_active;
  } out_beat_t;

  // phase stage -> wave stage
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [VEL_W-1:0]      vel;
    logic                  active;
  } s1_beat_t;

  // wave stage -> scale stage
  typedef struct packed {
    logic signed [RAW_W-1:0] raw_alt;
    logic                    use_sine;
    logic                    neg;
    logic [VEL_W-1:0]        vel;
    logic                    active;
  } s2_beat_t;

  typedef logic [PHASE_BITS-1:0] step_lut_t [NUM_KEYS];
  typedef logic [15:0]           sine_lut_t [SINE_DEPTH+1];

  // equal-tempered key frequencies in milli-hertz
  localparam int unsigned KEY_MHZ [NUM_KEYS] = '{
    8176, 8662, 9177, 9723, 10301, 10913, 11562, 12250, 12978, 13750,
    14568, 15434, 16352, 17324, 18354, 19445, 20602, 21827, 23125, 24500,
    25957, 27500, 29135, 30868, 32703, 34648, 36708, 38891, 41203, 43654,
    46249, 48999, 51913, 55000, 58271, 61735, 65406, 69296, 73416, 77782,
    82407, 87307, 92499, 97999, 103826, 110000, 116541, 123471, 130813, 138591,
    146832, 155563, 164814, 174614, 184997, 195998, 207652, 220000, 233082, 246942,
    261626, 277183, 293665, 311127, 329628, 349228, 369994, 391995, 415305, 440000,
    466164, 493883, 523251, 554365, 587330, 622254, 659255, 698456, 739989, 783991,
    830609, 880000, 932328, 987767, 1046500, 1108730, 1174660, 1244510, 1318510,
    1396910, 1479980, 1567980, 1661220, 1760000, 1864660, 1975530, 2093000, 2217460,
    2349320, 2489020, 2637020, 2793830, 2959960, 3135960, 3322440, 3520000, 3729310,
    3951070, 4186010, 4434920, 4698640, 4978030, 5274040, 5587650, 5919910, 6271930,
    6644880, 7040000, 7458620, 7902130, 8372020, 8869840, 9397270, 9956060, 10548100,
    11175300, 11839800, 12543900
  };

  // step = round(f * 2^PHASE_BITS / fs), halves up, mod 2^PHASE_BITS
  function automatic step_lut_t build_step_lut();
    step_lut_t       lut;
    longint unsigned num;
    longint unsigned q;
    longint unsigned r;
    for (int k = 0; k < NUM_KEYS; k++) begin
      num = longint'(KEY_MHZ[k]) << PHASE_BITS;
      q   = num / STEP_DEN;
      r   = num % STEP_DEN;
      if (2 * r >= STEP_DEN) q = q + 1;
      lut[k] = PHASE_BITS'(q);
    end
    return lut;
  endfunction

  // quarter sine in Q15, Taylor series to x^15 in Q30, rounded;
  // term n is the previous one times x^2 over (2n)(2n+1)
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t       lut;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint          sum;
    longint          r;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x   = longint'((HALF_PI_Q30 * k) / SINE_DEPTH);
      x2  = (x * x) >> 30;
      mag = x;
      sum = longint'(x);
      mag = ((mag * x2) >> 30) / 64'd6;
      sum = sum - longint'(mag);
      mag = ((mag * x2) >> 30) / 64'd20;
      sum = sum + longint'(mag);
      mag = ((mag * x2) >> 30) / 64'd42;
      sum = sum - longint'(mag);
      mag = ((mag * x2) >> 30) / 64'd72;
      sum = sum + longint'(mag);
      mag = ((mag * x2) >> 30) / 64'd110;
      sum = sum - longint'(mag);
      mag = ((mag * x2) >> 30) / 64'd156;
      sum = sum + longint'(mag);
      mag = ((mag * x2) >> 30) / 64'd210;
      sum = sum - longint'(mag);
      if (sum < 0) sum = 0;
      r = (sum + (64'd1 << 14)) >>> 15;
      if (r > 32768 || k == SINE_DEPTH) r = 32768;
      lut[k] = 16'(r);
    end
    return lut;
  endfunction

  localparam step_lut_t STEP_LUT = build_step_lut();

endpackage

[rtl/mdds_front.sv]
// ----------------------------------------------------------------------------
// mdds_front
// Command decode, voice state, wave-type register and phase accumulator.
// Each accepted tick leaves one beat in the stage-one register.
// ----------------------------------------------------------------------------
module mdds_front import mdds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  input  logic     cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  output wave_t    wave_type,
  input  logic     s1_ready,
  output logic     s1_valid,
  output s1_beat_t s1_data
);

  logic                  active_r,  active_nxt;
  logic [VEL_W-1:0]      vel_r,     vel_nxt;
  logic [PHASE_BITS-1:0] step_r,    step_nxt;
  logic [PHASE_BITS-1:0] phase_r,   phase_nxt;
  wave_t                 wave_r;
  logic                  s1_valid_r, s1_valid_nxt;
  s1_beat_t              s1_data_r,  s1_data_nxt;
  logic                  accept;
  logic                  is_tick;

  assign in_stall = s1_valid_r && !s1_ready;
  assign accept   = in_valid && !in_stall;
  assign is_tick  = (in_data.command == CMD_TICK);

  always_comb begin
    active_nxt   = active_r;
    vel_nxt      = vel_r;
    step_nxt     = step_r;
    phase_nxt    = phase_r;
    s1_valid_nxt = s1_valid_r && !s1_ready;
    s1_data_nxt  = s1_data_r;
    if (accept) begin
      unique case (in_data.command)
        CMD_TICK: begin
          if (active_r) phase_nxt = phase_r + step_r;
          s1_valid_nxt       = 1'b1;
          s1_data_nxt.phase  = phase_nxt;
          s1_data_nxt.vel    = active_r ? vel_r : '0;
          s1_data_nxt.active = active_r;
        end
        CMD_NOTE_ON: begin
          active_nxt = 1'b1;
          vel_nxt    = in_data.strike;
          step_nxt   = STEP_LUT[in_data.key];
        end
        CMD_NOTE_OFF: begin
          active_nxt = 1'b0;
        end
        default: ;  // reserved code: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      vel_r      <= '0;
      step_r     <= '0;
      phase_r    <= '0;
      wave_r     <= WAVE_SINE;
      s1_valid_r <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      vel_r      <= vel_nxt;
      step_r     <= step_nxt;
      phase_r    <= phase_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (cfg_wr_en) wave_r <= wave_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_tick) s1_data_r <= s1_data_nxt;
  end

  assign wave_type = wave_r;
  assign s1_valid  = s1_valid_r;
  assign s1_data   = s1_data_r;

endmodule

[rtl/mdds_wave.sv]
// ----------------------------------------------------------------------------
// mdds_wave
// Waveform stage: quarter-wave sine ROM with registered read, plus the
// sawtooth, square and triangle shapes taken straight from the phase.
// ----------------------------------------------------------------------------
module mdds_wave import mdds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  wave_t    wave_type,
  input  logic     s1_valid,
  output logic     s1_ready,
  input  s1_beat_t s1_data,
  input  logic     s2_ready,
  output logic     s2_valid,
  output s2_beat_t s2_data,
  output logic [15:0] s2_rom_q
);

  localparam sine_lut_t SINE_ROM = build_sine_lut();

  logic                  s2_valid_r;
  s2_beat_t              s2_data_r, s2_data_nxt;
  logic [15:0]           rom_q_r;
  logic                  load;
  logic [1:0]            quad;
  logic [SINE_AW-1:0]    idx;
  logic [ROM_AW-1:0]     rom_addr;
  logic [15:0]           u;
  logic signed [18:0]    u_s;
  logic signed [18:0]    tri_v;
  logic                  above_half;

  assign s1_ready = !s2_valid_r || s2_ready;
  assign load     = s1_valid && s1_ready;

  assign quad     = s1_data.phase[PHASE_BITS-1 -: 2];
  assign idx      = s1_data.phase[PHASE_BITS-3 -: SINE_AW];
  assign rom_addr = quad[0] ? (ROM_AW'(SINE_DEPTH) - {1'b0, idx}) : {1'b0, idx};

  assign u          = s1_data.phase[PHASE_BITS-1 -: 16];
  assign u_s        = signed'({3'b000, u});
  assign tri_v      = u[15] ? (19'sd98304 - (u_s <<< 1)) : ((u_s <<< 1) - 19'sd32768);
  assign above_half = s1_data.phase[PHASE_BITS-1] && (|s1_data.phase[PHASE_BITS-2:0]);

  always_comb begin
    s2_data_nxt          = '0;
    s2_data_nxt.neg      = quad[1];
    s2_data_nxt.vel      = s1_data.vel;
    s2_data_nxt.active   = s1_data.active;
    s2_data_nxt.use_sine = 1'b0;
    unique case (wave_type)
      WAVE_SINE:   s2_data_nxt.use_sine = 1'b1;
      WAVE_RAMP:   s2_data_nxt.raw_alt  = RAW_W'(signed'({~u[15], u[14:0]}));
      WAVE_PULSE:  s2_data_nxt.raw_alt  = above_half ? 17'sd32768 : -17'sd32768;
      WAVE_TENT:   s2_data_nxt.raw_alt  = RAW_W'(tri_v);
      default:     s2_data_nxt.raw_alt  = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s2_data_r <= s2_data_nxt;
      rom_q_r   <= SINE_ROM[rom_addr];
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_data_r;
  assign s2_rom_q = rom_q_r;

endmodule

[rtl/mdds_scale.sv]
// ----------------------------------------------------------------------------
// mdds_scale
// Velocity scaling: raw * vel, then round(/127) by reciprocal multiply,
// sign restore and saturation into the output register.
// ----------------------------------------------------------------------------
module mdds_scale import mdds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s2_valid,
  output logic        s2_ready,
  input  s2_beat_t    s2_data,
  input  logic [15:0] s2_rom_q,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data
);

  logic                     s3_valid_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     s3_active_r;
  logic                     s3_ready;
  logic                     out_valid_r;
  out_beat_t                out_data_r, out_data_nxt;
  logic                     out_ready;

  logic signed [RAW_W-1:0]  rom_s;
  logic signed [RAW_W-1:0]  raw;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_neg;
  logic [PROD_W-1:0]        prod_abs;
  logic [MAG_W-1:0]         mag;
  logic [MAG_W+RECIP_W-1:0] qfull;
  logic [16:0]              q;

  assign out_ready = !out_valid_r || !out_stall;
  assign s3_ready  = !s3_valid_r || out_ready;
  assign s2_ready  = s3_ready;

  // stage 3: signed raw sample times velocity
  assign rom_s = signed'({1'b0, s2_rom_q});
  assign raw   = s2_data.use_sine ? (s2_data.neg ? -rom_s : rom_s) : s2_data.raw_alt;
  assign prod  = PROD_W'(raw) * PROD_W'(signed'({1'b0, s2_data.vel}));

  // output stage: |prod| rounded / 127
  assign prod_neg = prod_r[PROD_W-1];
  assign prod_abs = prod_neg ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign mag      = MAG_W'(prod_abs) + MAG_W'(RND_BIAS);
  assign qfull    = (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(RECIP_MUL);
  assign q        = qfull[RECIP_SHIFT +: 17];

  always_comb begin
    out_data_nxt.voice_active = s3_active_r;
    if (prod_neg)       out_data_nxt.sample_out = SAMPLE_W'(-signed'(q));
    else if (q[16] || q[15]) out_data_nxt.sample_out = 16'sd32767;
    else                out_data_nxt.sample_out = signed'(q[15:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s3_ready)  s3_valid_r  <= s2_valid;
      if (out_ready) out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      prod_r      <= prod;
      s3_active_r <= s2_data.active;
    end
    if (s3_valid_r && out_ready) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/midi_voice_dds_oscillator_unit.sv]
// ----------------------------------------------------------------------------
// midi_voice_dds_oscillator_unit
// Single-voice MIDI oscillator: note on / note off / sample tick commands
// drive a 32-bit phase accumulator and a sine, saw, square or triangle shape.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while out_stall is low. Four register stages
//   (input, sine ROM read, velocity multiply, /127 reciprocal multiply) each
//   hold one beat; a tick beat passes them in that order on its way to out_*.
// Note on / note off beats update the voice at acceptance and give no result.
// Reset: synchronous, active low; voice idle, phase and step zero, sine
//   selected, all stages empty. No clearing pass.
// ----------------------------------------------------------------------------
module midi_voice_dds_oscillator_unit import mdds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  // command channel
  input  logic       in_valid,
  output logic       in_stall,
  input  in_beat_t   in_data,
  // sample channel
  output logic       out_valid,
  input  logic       out_stall,
  output out_beat_t  out_data,
  // wave type register
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  wave_t       wave_type;
  logic        s1_valid, s1_ready;
  s1_beat_t    s1_data;
  logic        s2_valid, s2_ready;
  s2_beat_t    s2_data;
  logic [15:0] s2_rom_q;

  // Front end: commands act on the voice state the moment they are taken;
  // only ticks travel down the pipe. The phase only moves while a note is on.
  mdds_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .wave_type   (wave_type),
    .s1_ready    (s1_ready),
    .s1_valid    (s1_valid),
    .s1_data     (s1_data)
  );

  // Shape stage: quarter-wave sine ROM (mirror in odd quadrants, negate in
  // the lower half) read into a register; other shapes come from the phase.
  mdds_wave u_wave (
    .clk       (clk),
    .rst_n     (rst_n),
    .wave_type (wave_type),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_data   (s1_data),
    .s2_ready  (s2_ready),
    .s2_valid  (s2_valid),
    .s2_data   (s2_data),
    .s2_rom_q  (s2_rom_q)
  );

  // Scale stage: amplitude by velocity/127, rounded half away from zero;
  // full-scale positive clips to 32767. An idle voice carries velocity zero,
  // so its beat comes out as zero with voice_active low.
  mdds_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2_ready  (s2_ready),
    .s2_data   (s2_data),
    .s2_rom_q  (s2_rom_q),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/mdds_chk.sv]
// ----------------------------------------------------------------------------
// mdds_chk
// Port-level checks for the oscillator, bound onto the top level.
// ----------------------------------------------------------------------------
module mdds_chk import mdds_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input out_beat_t  out_data
);

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // an idle voice only ever gives silence
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.voice_active) |-> (out_data.sample_out == '0))
    else $error("non-zero sample from idle voice");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  // input side frees up while the result register is free
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid && !$past(in_valid) && !$past(in_valid, 2) && !$past(in_valid, 3))
      |-> !in_stall)
    else $error("input stalled with empty pipeline");

endmodule

bind midi_voice_dds_oscillator_unit mdds_chk u_mdds_chk (.*);

[dv/tb_midi_voice_dds_oscillator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_midi_voice_dds_oscillator_unit
// Self-checking bench for the single-voice DDS oscillator. Command beats go in
// through a bursty sender. A behavioural voice model predicts one sample beat
// per tick. A checker on the sample channel compares each beat, field by
// field, against the oldest prediction while the receiver stalls in changing
// patterns. Directed tests cover the idle voice and the field extremes.
// Random phrases follow under each wave type.
// ----------------------------------------------------------------------------
module tb_midi_voice_dds_oscillator_unit;
  import mdds_pkg::*;

  localparam int              QTR_DEPTH        = 1024;
  localparam longint          QUARTER_TURN_Q30 = 64'd1686629713;   // pi/2 in Q30
  localparam longint unsigned FS_MILLI         = 64'd48000000;     // 48 kHz in mHz
  localparam logic [1:0]      CMD_UNUSED       = 2'd3;             // no such command
  localparam int              DRAIN_CYCLES     = 8;
  localparam int              REPORT_CAP       = 100;
  localparam longint          LIMIT_NS         = 64'd20_000_000;

  // equal-tempered key frequencies, milli-hertz, key 0 upwards
  localparam int unsigned NOTE_MHZ [128] = '{
    8176, 8662, 9177, 9723, 10301, 10913, 11562, 12250, 12978, 13750,
    14568, 15434, 16352, 17324, 18354, 19445, 20602, 21827, 23125, 24500,
    25957, 27500, 29135, 30868, 32703, 34648, 36708, 38891, 41203, 43654,
    46249, 48999, 51913, 55000, 58271, 61735, 65406, 69296, 73416, 77782,
    82407, 87307, 92499, 97999, 103826, 110000, 116541, 123471, 130813, 138591,
    146832, 155563, 164814, 174614, 184997, 195998, 207652, 220000, 233082, 246942,
    261626, 277183, 293665, 311127, 329628, 349228, 369994, 391995, 415305, 440000,
    466164, 493883, 523251, 554365, 587330, 622254, 659255, 698456, 739989, 783991,
    830609, 880000, 932328, 987767, 1046500, 1108730, 1174660, 1244510, 1318510,
    1396910, 1479980, 1567980, 1661220, 1760000, 1864660, 1975530, 2093000, 2217460,
    2349320, 2489020, 2637020, 2793830, 2959960, 3135960, 3322440, 3520000, 3729310,
    3951070, 4186010, 4434920, 4698640, 4978030, 5274040, 5587650, 5919910, 6271930,
    6644880, 7040000, 7458620, 7902130, 8372020, 8869840, 9397270, 9956060, 10548100,
    11175300, 11839800, 12543900
  };

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_beat_t  out_data;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  // voice model: register copy plus the four state words
  wave_t      wave_sel;
  bit         voice_on;
  bit [6:0]   vel_held;
  bit [31:0]  step_reg;
  bit [31:0]  phase_reg;
  int         sine_rom [0:QTR_DEPTH];

  out_beat_t  pending_samples [$];   // predicted sample beats, oldest first
  int         mismatches;
  int         burst_left;
  bit         paced;                 // 0: sender runs back to back

  midi_voice_dds_oscillator_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Voice model
  // --------------------------------------------------------------------------

  // Quarter-wave sine in Q15: Taylor series to x^15 carried in Q30, then
  // rounded; the top entry is pinned to +1.0.
  function automatic void fill_sine_rom();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint          r;
    for (int k = 0; k < QTR_DEPTH; k++) begin
      x    = (QUARTER_TURN_Q30 * k) / QTR_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'(4 * n * n + 2 * n);
        acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      r = (acc + 16384) / 32768;
      sine_rom[k] = (r > 32768) ? 32768 : int'(r);
    end
    sine_rom[QTR_DEPTH] = 32768;
  endfunction

  // f * 2^32 / fs, halves rounded up; keys above fs simply wrap
  function automatic bit [31:0] key_phase_step(bit [6:0] key);
    longint unsigned scaled;
    longint unsigned q;
    scaled = {NOTE_MHZ[key], 32'h0};
    q = scaled / FS_MILLI;
    if (2 * (scaled % FS_MILLI) >= FS_MILLI) q++;
    return q[31:0];
  endfunction

  // raw shape in Q15 with +1.0 = 32768
  function automatic int shape_sample(bit [31:0] ph, wave_t w);
    bit [15:0] u;
    bit [11:0] n;
    int        idx;
    int        v;
    u = ph[31:16];
    n = ph[31:20];
    case (w)
      WAVE_SINE: begin
        // bit 10 mirrors the quarter, bit 11 flips the sign
        idx = n[10] ? QTR_DEPTH - int'(n[9:0]) : int'(n[9:0]);
        v   = n[11] ? -sine_rom[idx] : sine_rom[idx];
      end
      WAVE_RAMP:   v = int'(u) - 32768;
      WAVE_PULSE:  v = (ph > 32'h8000_0000) ? 32768 : -32768;
      default:     v = u[15] ? (49152 - int'(u)) * 2 : (int'(u) - 16384) * 2;
    endcase
    return v;
  endfunction

  // raw * vel / 127, nearest with halves away from zero, then saturated
  function automatic logic signed [15:0] scale_by_velocity(int raw, bit [6:0] vel);
    longint prod;
    longint mag;
    prod = longint'(raw) * longint'(vel);
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + 63) / 127;
    if (prod < 0) mag = -mag;
    if (mag > 32767) mag = 32767;
    if (mag < -32768) mag = -32768;
    return 16'(mag);
  endfunction

  // apply one accepted command beat; a tick queues its sample beat
  function automatic void voice_accept(in_beat_t b);
    out_beat_t res;
    case (b.command)
      CMD_NOTE_ON: begin
        voice_on = 1'b1;
        vel_held = b.strike;
        step_reg = key_phase_step(b.key);
      end
      CMD_NOTE_OFF: voice_on = 1'b0;
      CMD_TICK: begin
        if (voice_on) begin
          phase_reg        = phase_reg + step_reg;
          res.sample_out   = scale_by_velocity(shape_sample(phase_reg, wave_sel), vel_held);
          res.voice_active = 1'b1;
        end else begin
          // silent voice: phase holds
          res.sample_out   = '0;
          res.voice_active = 1'b0;
        end
        pending_samples.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Command sender
  // --------------------------------------------------------------------------

  task automatic hold_off(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // bursts of random length, random gaps between them
  task automatic pace();
    int r;
    if (!paced) return;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      r = $urandom_range(0, 9);
      if (r >= 8)      hold_off($urandom_range(5, 30));
      else if (r >= 4) hold_off($urandom_range(1, 4));
    end
    burst_left--;
  endtask

  task automatic send_beat(in_beat_t b);
    pace();
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    voice_accept(b);
  endtask

  task automatic send_cmd(logic [1:0] cmd, logic [6:0] key, logic [6:0] strike);
    in_beat_t b;
    b.command = cmd;
    b.key     = key;
    b.strike  = strike;
    send_beat(b);
  endtask

  // drop valid, let every predicted sample out, then wait out the drain margin
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_wave(wave_t w);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    @(posedge clk);
    wave_sel = w;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sample checker and receiver stall pattern
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk) begin : sample_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample beat with none predicted: %0d active %0b",
                                  out_data.sample_out, out_data.voice_active));
      end else begin
        want = pending_samples.pop_front();
        if (out_data.sample_out !== want.sample_out)
          report_mismatch($sformatf("sample_out got %0d want %0d",
                                    out_data.sample_out, want.sample_out));
        if (out_data.voice_active !== want.voice_active)
          report_mismatch($sformatf("voice_active got %0b want %0b",
                                    out_data.voice_active, want.voice_active));
      end
    end
  end

  // free flow, light, heavy and periodic stalling, each for a random stretch
  initial begin : stall_pattern
    flow_mode_t mode;
    int         left;
    int         count;
    out_stall = 1'b0;
    mode      = FLOW_FREE;
    left      = 0;
    count     = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = flow_mode_t'($urandom_range(0, 3));
        left = $urandom_range(16, 96);
      end
      left--;
      count++;
      case (mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        FLOW_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:    out_stall <= (count % 5 < 3);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // extremes now and then, high keys favoured so the phase sweeps quickly
  function automatic logic [6:0] pick_key();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'd127;
    if (r < 11) return 7'($urandom_range(96, 127));
    return 7'($urandom);
  endfunction

  function automatic logic [6:0] pick_strike();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 7'd0;
    if (r == 1) return 7'd127;
    return 7'($urandom);
  endfunction

  // note on, a run of ticks with the odd retrigger or junk beat, maybe a
  // note off with a few silent ticks after it
  task automatic play_phrase(output int sent);
    int ticks;
    sent = 0;
    send_cmd(CMD_NOTE_ON, pick_key(), pick_strike());
    sent++;
    ticks = $urandom_range(1, 24);
    repeat (ticks) begin
      case ($urandom_range(0, 19))
        0: send_cmd(CMD_UNUSED, 7'($urandom), 7'($urandom));
        1: begin
          send_cmd(CMD_NOTE_ON, pick_key(), pick_strike());
          sent++;
        end
        default: ;
      endcase
      send_cmd(CMD_TICK, 7'($urandom), 7'($urandom));
      sent++;
    end
    if ($urandom_range(0, 9) < 6) begin
      send_cmd(CMD_NOTE_OFF, 7'($urandom), 7'($urandom));
      sent++;
      repeat ($urandom_range(0, 3)) begin
        send_cmd(CMD_TICK, 7'($urandom), 7'($urandom));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // voice never struck: ticks give silent beats, off and junk change nothing
  task automatic test_idle_voice();
    send_cmd(CMD_TICK, 7'h7f, 7'h7f);
    send_cmd(CMD_NOTE_OFF, 7'h00, 7'h00);
    send_cmd(CMD_UNUSED, 7'h7f, 7'h00);
    send_cmd(CMD_TICK, 7'h00, 7'h00);
  endtask

  // lowest and highest key, full and zero velocity, retrigger keeping the
  // phase, junk beat while sounding, release
  task automatic test_note_extremes();
    send_cmd(CMD_NOTE_ON, 7'd0, 7'd127);
    repeat (2) send_cmd(CMD_TICK, 7'h00, 7'h00);
    send_cmd(CMD_NOTE_ON, 7'd127, 7'd127);
    repeat (3) send_cmd(CMD_TICK, 7'h7f, 7'h7f);
    send_cmd(CMD_NOTE_ON, 7'd69, 7'd0);
    send_cmd(CMD_TICK, 7'h00, 7'h7f);
    send_cmd(CMD_NOTE_ON, 7'd127, 7'd1);
    send_cmd(CMD_TICK, 7'h7f, 7'h00);
    send_cmd(CMD_UNUSED, 7'h00, 7'h00);
    send_cmd(CMD_TICK, 7'h00, 7'h00);
    send_cmd(CMD_NOTE_OFF, 7'h7f, 7'h7f);
    send_cmd(CMD_TICK, 7'h00, 7'h00);
  endtask

  // mostly well-formed phrases, a tenth fully random beats; junk commands
  // do not count towards the quota
  task automatic test_random_voice(wave_t w, int quota, bit steady);
    int         done;
    int         n;
    logic [1:0] cmd;
    write_wave(w);
    paced = !steady;
    done  = 0;
    while (done < quota) begin
      if ($urandom_range(0, 9) == 0) begin
        cmd = 2'($urandom);
        send_cmd(cmd, 7'($urandom), 7'($urandom));
        if (cmd != CMD_UNUSED) done++;
      end else begin
        play_phrase(n);
        done += n;
      end
    end
    paced = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = WAVE_SINE;
    rst_n       = 1'b0;
    mismatches  = 0;
    burst_left  = 0;
    paced       = 1'b1;
    wave_sel    = WAVE_SINE;
    voice_on    = 1'b0;
    vel_held    = '0;
    step_reg    = '0;
    phase_reg   = '0;
    fill_sine_rom();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset leaves sine selected
    test_idle_voice();
    test_note_extremes();

    test_random_voice(WAVE_TENT,   240, 1'b0);
    test_random_voice(WAVE_SINE,   240, 1'b1);
    test_random_voice(WAVE_RAMP,   240, 1'b0);
    test_random_voice(WAVE_PULSE,  240, 1'b0);
    test_random_voice(WAVE_SINE,   240, 1'b0);

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("simulation failed");
    $finish;
  end

endmodule
